[rtl/gdad_pkg.sv]
// Shared types, constants and calendar helpers for the date adder.
`default_nettype none
package gdad_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 16;
  localparam int CYC_W   = 9;
  localparam int QUOT_W  = 6;
  localparam int PROD_W  = 27;

  localparam int RECIP_SHIFT = 21;
  localparam logic [PROD_W-1:0] YEAR_RECIP = PROD_W'(5243);
  localparam logic [CYC_W-1:0] LEAP_CYCLE = CYC_W'(400);
  localparam logic [CYC_W-1:0] CYCLE_LAST = CYC_W'(399);
  localparam logic [YEAR_W-1:0] YEAR_LAST = {YEAR_W{1'b1}};

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W:0]   MONTH_DEC = (MONTH_W+1)'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
  } ctrl_sts_t;

  function automatic logic leap_of(input logic [CYC_W-1:0] r);
    logic century;
    begin
      century = (r == CYC_W'(100)) || (r == CYC_W'(200)) || (r == CYC_W'(300));
      leap_of = (r[1:0] == 2'b00) && !century;
    end
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] mon,
                                                    input logic leap);
    begin
      case (mon)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_length = DAY_W'(31);
        4'd4, 4'd6, 4'd9, 4'd11:                    month_length = DAY_W'(30);
        MONTH_FEB: month_length = leap ? DAY_W'(29) : DAY_W'(28);
        default:   month_length = DAY_W'(0);
      endcase
    end
  endfunction

endpackage
`default_nettype wire

[rtl/gdad_ctrl.sv]
// Controller state machine sequencing setup, day stepping and result hand-off.
`default_nettype none
module gdad_ctrl
  import gdad_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (sts.count_zero) begin
          state_next = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/gdad_dp.sv]
// Datapath holding the running date, day counter and year position in the leap cycle.
`default_nettype none
module gdad_dp
  import gdad_pkg::*;
(
  input  wire logic               clk,
  input  wire ctrl_cmd_t          cmd,
  output ctrl_sts_t               sts,
  input  wire logic [DAY_W-1:0]   start_day,
  input  wire logic [MONTH_W-1:0] start_month,
  input  wire logic [YEAR_W-1:0]  start_year,
  input  wire logic [COUNT_W-1:0] day_count,
  output logic [DAY_W-1:0]        end_day,
  output logic [MONTH_W-1:0]      end_month,
  output logic [YEAR_W-1:0]       end_year
);

  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] mon;
  logic [YEAR_W-1:0]  yr;
  logic [COUNT_W-1:0] left;
  logic [QUOT_W-1:0]  quot;
  logic [CYC_W-1:0]   cyc;

  logic [PROD_W-1:0]  prod;
  logic [YEAR_W:0]    quot_mul;
  logic [YEAR_W:0]    year_rem;
  logic [DAY_W-1:0]   max_day;
  logic [DAY_W:0]     day_inc;
  logic [MONTH_W:0]   mon_inc;

  assign prod     = PROD_W'(start_year) * YEAR_RECIP;
  assign quot_mul = (YEAR_W+1)'(quot) * (YEAR_W+1)'(LEAP_CYCLE);
  assign year_rem = {1'b0, yr} - quot_mul;
  assign max_day  = month_length(mon, leap_of(cyc));
  assign day_inc  = {1'b0, day} + (DAY_W+1)'(1);
  assign mon_inc  = {1'b0, mon} + (MONTH_W+1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day  <= start_day;
      mon  <= start_month;
      yr   <= start_year;
      left <= day_count;
      quot <= prod[RECIP_SHIFT +: QUOT_W];
    end else if (cmd.setup) begin
      cyc <= year_rem[CYC_W-1:0];
    end else if (cmd.step) begin
      left <= left - COUNT_W'(1);
      if (day_inc > {1'b0, max_day}) begin
        day <= DAY_FIRST;
        if (mon_inc > MONTH_DEC) begin
          mon <= MONTH_JAN;
          yr  <= yr + YEAR_W'(1);
          if (yr == YEAR_LAST || cyc == CYCLE_LAST) begin
            cyc <= '0;
          end else begin
            cyc <= cyc + CYC_W'(1);
          end
        end else begin
          mon <= mon_inc[MONTH_W-1:0];
        end
      end else begin
        day <= day_inc[DAY_W-1:0];
      end
    end
  end

  assign sts.count_zero = (left == '0);
  assign end_day   = day;
  assign end_month = mon;
  assign end_year  = yr;

endmodule
`default_nettype wire

[rtl/gregorian_date_add_days.sv]
// Top level: advances a Gregorian date by a count of days, one day per cycle.
// Sequence: the accepted input is loaded, the leap-cycle position is set up, then days are
// stepped until the count is zero and out_valid is raised; one transaction at a time, and
// the stepping loop in the datapath advances one day per cycle.
// Reset: synchronous, active high; returns the controller to idle, no result pending.
`default_nettype none
module gregorian_date_add_days
  import gdad_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [DAY_W-1:0]   start_day,
  input  wire logic [MONTH_W-1:0] start_month,
  input  wire logic [YEAR_W-1:0]  start_year,
  input  wire logic [COUNT_W-1:0] day_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [DAY_W-1:0]        end_day,
  output logic [MONTH_W-1:0]      end_month,
  output logic [YEAR_W-1:0]       end_year
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  gdad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdad_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .day_count   (day_count),
    .end_day     (end_day),
    .end_month   (end_month),
    .end_year    (end_year)
  );

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result shown in the cycle after accept");

  a_zero_count_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && day_count == '0) |-> ##3 out_valid)
    else $error("zero day count did not finish in three cycles");

  a_result_holds_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sts.count_zero)
    else $error("result presented before all days were applied");

endmodule
`default_nettype wire
